// ===== rtl/lfu_pkg.sv =====
// Shared types and constants for the LFU cache lookup and eviction block.
// Used by lfu_ctrl, lfu_datapath, the top level and the checker.
package lfu_pkg;

   localparam int ENTRIES    = 64;
   localparam int IDX_BITS   = 6;
   localparam int LINE_SHIFT = 6;
   localparam int ADDR_BITS  = 64;
   localparam int TAG_BITS   = 58;
   localparam int COUNT_BITS = 16;
   localparam int CAP_BITS   = 7;
   localparam int TOTAL_BITS = 32;
   localparam int KEY_BITS   = 1 + COUNT_BITS + IDX_BITS;
   localparam int TREE_FAN   = 4;
   localparam int TREE_STEPS = 3;
   localparam int STEP_BITS  = 2;

   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(ENTRIES);
   localparam logic REQ_ACCESS = 1'b0;
   localparam logic REQ_FLUSH  = 1'b1;

   typedef struct packed {
      logic                 req_type;
      logic [ADDR_BITS-1:0] byte_address;
   } lfu_req_type;

   typedef struct packed {
      logic                  hit;
      logic                  evict_valid;
      logic [TAG_BITS-1:0]   evicted_line;
      logic [TOTAL_BITS-1:0] hit_count;
      logic [TOTAL_BITS-1:0] miss_count;
   } lfu_rsp_type;

   typedef struct packed {
      logic load;
      logic look;
      logic step;
      logic update;
   } lfu_cmd_type;

   typedef struct packed {
      logic hit;
      logic flush;
      logic evict;
      logic rsp_busy;
   } lfu_stat_type;

endpackage

// ===== rtl/lfu_ctrl.sv =====
// Sequencer for one access: lookup, victim search, update, result.
// Depends on lfu_pkg for the command and status structs.
module lfu_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lfu_pkg::lfu_stat_type stat,
   output lfu_pkg::lfu_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOOK = 3'd1;
   localparam logic [2:0] S_DEC  = 3'd2;
   localparam logic [2:0] S_TREE = 3'd3;
   localparam logic [2:0] S_UPD  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [lfu_pkg::STEP_BITS-1:0] step_ff, step_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.look = 1'b1;
            state_in = S_DEC;
         end
         S_DEC: begin
            step_in = '0;
            if (!stat.flush && !stat.hit && stat.evict) state_in = S_TREE;
            else state_in = S_UPD;
         end
         S_TREE: begin
            cmd.step = 1'b1;
            step_in  = step_ff + 1'b1;
            if (step_ff == lfu_pkg::STEP_BITS'(lfu_pkg::TREE_STEPS - 1)) state_in = S_UPD;
         end
         S_UPD: begin
            if (!stat.rsp_busy) begin
               cmd.update = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ===== rtl/lfu_datapath.sv =====
// Line store, tag compare, registered victim tree, counters and result register.
// Depends on lfu_pkg; driven by commands from lfu_ctrl.
module lfu_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  lfu_pkg::lfu_req_type                req_payload,
   input  logic                                csr_write_enable,
   input  logic [lfu_pkg::CAP_BITS-1:0]        csr_write_data,
   input  lfu_pkg::lfu_cmd_type                cmd,
   output lfu_pkg::lfu_stat_type               stat,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output lfu_pkg::lfu_rsp_type                rsp_payload
);

   typedef struct packed {
      logic [lfu_pkg::KEY_BITS-1:0] key;
      logic [lfu_pkg::IDX_BITS-1:0] idx;
      logic [lfu_pkg::TAG_BITS-1:0] tag;
   } lfu_node_type;

   function automatic lfu_node_type min2(input lfu_node_type a, input lfu_node_type b);
      min2 = (b.key < a.key) ? b : a;
   endfunction

   logic                           flush_ff;
   logic [lfu_pkg::TAG_BITS-1:0]   line_ff;
   logic [lfu_pkg::ENTRIES-1:0]    valid_ff, valid_in;
   logic [lfu_pkg::COUNT_BITS-1:0] count_ff [lfu_pkg::ENTRIES];
   logic [lfu_pkg::COUNT_BITS-1:0] count_in [lfu_pkg::ENTRIES];
   logic [lfu_pkg::IDX_BITS-1:0]   rank_ff  [lfu_pkg::ENTRIES];
   logic [lfu_pkg::IDX_BITS-1:0]   rank_in  [lfu_pkg::ENTRIES];
   logic [lfu_pkg::TAG_BITS-1:0]   tag_ff   [lfu_pkg::ENTRIES];
   logic [lfu_pkg::ENTRIES-1:0]    tag_we;
   lfu_node_type                   node_ff  [lfu_pkg::ENTRIES];
   lfu_node_type                   node_in  [lfu_pkg::ENTRIES];
   logic [lfu_pkg::ENTRIES-1:0]    match, hitvec_ff, free_ff, free_vec;
   logic                           hit_ff, evict_ff;
   logic [lfu_pkg::IDX_BITS-1:0]   hitrank_ff, hitrank;
   logic [lfu_pkg::CAP_BITS-1:0]   cap_ff, cap_eff, nvalid_ff, nvalid_in;
   logic [lfu_pkg::TOTAL_BITS-1:0] hits_ff, hits_in, misses_ff, misses_in;
   logic [lfu_pkg::IDX_BITS-1:0]   victim_rank;
   logic                           rsp_valid_ff;
   lfu_pkg::lfu_rsp_type           rsp_ff;

   assign stat.hit      = hit_ff;
   assign stat.flush    = flush_ff;
   assign stat.evict    = evict_ff;
   assign stat.rsp_busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_payload   = rsp_ff;

   assign cap_eff = (cap_ff == '0) ? lfu_pkg::CAP_BITS'(1) :
                    (cap_ff > lfu_pkg::CAP_RESET) ? lfu_pkg::CAP_RESET : cap_ff;
   assign free_vec    = ~valid_ff & (valid_ff + lfu_pkg::ENTRIES'(1));
   assign victim_rank = ~node_ff[0].key[lfu_pkg::IDX_BITS-1:0];

   always_comb begin
      hitrank = '0;
      for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
         match[i] = valid_ff[i] && (tag_ff[i] == line_ff);
         if (match[i]) hitrank = hitrank | rank_ff[i];
      end
   end

   always_comb begin
      for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
         node_in[i] = node_ff[i];
         if (cmd.look) begin
            node_in[i].key = {~valid_ff[i], count_ff[i], ~rank_ff[i]};
            node_in[i].idx = lfu_pkg::IDX_BITS'(i);
            node_in[i].tag = tag_ff[i];
         end
      end
      if (cmd.step) begin
         for (int i = 0; i < lfu_pkg::ENTRIES / lfu_pkg::TREE_FAN; i++) begin
            node_in[i] = min2(min2(node_ff[4*i], node_ff[4*i+1]),
                              min2(node_ff[4*i+2], node_ff[4*i+3]));
         end
      end
   end

   always_comb begin
      valid_in  = valid_ff;
      nvalid_in = nvalid_ff;
      tag_we    = '0;
      hits_in   = hits_ff;
      misses_in = misses_ff;
      for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
         count_in[i] = count_ff[i];
         rank_in[i]  = rank_ff[i];
      end
      if (cmd.update) begin
         if (flush_ff) begin
            valid_in  = '0;
            nvalid_in = '0;
            for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
               count_in[i] = '0;
               rank_in[i]  = '0;
            end
         end else if (hit_ff) begin
            if (hits_ff != '1) hits_in = hits_ff + 1'b1;
            for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
               if (hitvec_ff[i]) begin
                  if (count_ff[i] != '1) count_in[i] = count_ff[i] + 1'b1;
                  rank_in[i] = '0;
               end else if (valid_ff[i] && rank_ff[i] < hitrank_ff) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
            end
         end else begin
            if (misses_ff != '1) misses_in = misses_ff + 1'b1;
            if (!evict_ff) nvalid_in = nvalid_ff + 1'b1;
            for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
               if (evict_ff ? (node_ff[0].idx == lfu_pkg::IDX_BITS'(i)) : free_ff[i]) begin
                  tag_we[i]   = 1'b1;
                  valid_in[i] = 1'b1;
                  count_in[i] = lfu_pkg::COUNT_BITS'(1);
                  rank_in[i]  = '0;
               end else if (valid_ff[i] && !(evict_ff && rank_ff[i] > victim_rank)) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         flush_ff <= (req_payload.req_type == lfu_pkg::REQ_FLUSH);
         line_ff  <= req_payload.byte_address[lfu_pkg::LINE_SHIFT +: lfu_pkg::TAG_BITS];
      end
      if (cmd.look) begin
         hitvec_ff  <= match;
         hit_ff     <= |match;
         hitrank_ff <= hitrank;
         free_ff    <= free_vec;
         evict_ff   <= (nvalid_ff >= cap_eff);
      end
      for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
         node_ff[i] <= node_in[i];
         if (tag_we[i]) tag_ff[i] <= line_ff;
      end
      if (cmd.update) begin
         rsp_ff.hit          <= !flush_ff && hit_ff;
         rsp_ff.evict_valid  <= !flush_ff && !hit_ff && evict_ff;
         rsp_ff.evicted_line <= (!flush_ff && !hit_ff && evict_ff) ? node_ff[0].tag : '0;
         rsp_ff.hit_count    <= hits_in;
         rsp_ff.miss_count   <= misses_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         nvalid_ff    <= '0;
         cap_ff       <= lfu_pkg::CAP_RESET;
         hits_ff      <= '0;
         misses_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
            count_ff[i] <= '0;
            rank_ff[i]  <= '0;
         end
      end else begin
         valid_ff  <= valid_in;
         nvalid_ff <= nvalid_in;
         hits_ff   <= hits_in;
         misses_ff <= misses_in;
         if (csr_write_enable) cap_ff <= csr_write_data;
         if (cmd.update) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
            count_ff[i] <= count_in[i];
            rank_ff[i]  <= rank_in[i];
         end
      end
   end

endmodule

// ===== rtl/lfu_cache_lookup_evict.sv =====
// Fully associative LFU cache tag lookup with eviction; top level.
// Each request passes the load, lookup, decision and update states; a miss that evicts
// also runs three steps of the 4-way victim tree. The update waits while a result
// is stalled, and no new request is taken until the update (req_stall is high).
// Reset (synchronous): all lines invalid, counters zero, capacity 64.
// Depends on lfu_pkg, lfu_ctrl and lfu_datapath.
module lfu_cache_lookup_evict (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  lfu_pkg::lfu_req_type         req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output lfu_pkg::lfu_rsp_type         rsp_payload,
   input  logic                         csr_write_enable,
   input  logic [lfu_pkg::CAP_BITS-1:0] csr_write_data
);

   lfu_pkg::lfu_cmd_type  cmd;
   lfu_pkg::lfu_stat_type stat;

   lfu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   lfu_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload)
   );

endmodule

// ===== rtl/lfu_checker.sv =====
// Port-level checks for lfu_cache_lookup_evict, bound to the top level.
// Depends on lfu_pkg.
module lfu_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input lfu_pkg::lfu_rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   a_no_evict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.evict_valid |-> rsp_payload.evicted_line == '0)
      else $error("evicted line nonzero without eviction");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.hit |-> !rsp_payload.evict_valid)
      else $error("hit reported with eviction");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind lfu_cache_lookup_evict lfu_checker u_lfu_checker (.*);
